FILE: rtl/midi_mono_note_priority_parser_core_macros.svh
// Assertion macros for the MIDI mono note-priority parser.
// Used by the checker; depends on nothing else.
`ifndef MIDI_MONO_NOTE_PRIORITY_PARSER_CORE_MACROS_SVH
`define MIDI_MONO_NOTE_PRIORITY_PARSER_CORE_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define MMNP_ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the block's own clock and reset.
`define MMNP_ASSERT(lbl, prop, msg) \
  `MMNP_ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

FILE: rtl/mmnp_pkg.sv
// Shared types and constants for the MIDI mono note-priority parser.
// Used by mmnp_cell and the top level; no dependencies.
package mmnp_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 8;
  localparam int unsigned KEY_W           = 7;

  // Held-note stack command, one per cycle, same for every cell.
  typedef enum logic [1:0] {
    OP_NONE,
    OP_APPEND,
    OP_SHIFT,
    OP_REMOVE
  } stk_op_e;

  typedef struct packed {
    stk_op_e          op;
    logic [KEY_W-1:0] key;
  } cmd_t;

  // Forward link from one cell to the next.
  // rm : some earlier (or this) valid cell matches cmd key (combinational)
  // tok: max-scan wavefront, acc: running max so far (registered)
  typedef struct packed {
    logic             rm;
    logic             tok;
    logic [KEY_W-1:0] acc;
  } link_t;

endpackage

FILE: rtl/mmnp_cell.sv
// One entry of the held-note stack: key storage, match, shift and max-scan step.
// Depends on mmnp_pkg.
module mmnp_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  mmnp_pkg::cmd_t                   cmd_i,
  input  logic                             valid_i,
  input  logic                             prev_valid_i,
  input  logic [mmnp_pkg::KEY_W-1:0]       next_key_i,
  input  mmnp_pkg::link_t                  link_i,
  output logic [mmnp_pkg::KEY_W-1:0]       key_o,
  output mmnp_pkg::link_t                  link_o
);
  import mmnp_pkg::*;

  logic [KEY_W-1:0] key_q, key_d;
  logic [KEY_W-1:0] acc_q, acc_d;
  logic             tok_q;
  logic             match;
  logic             rm_incl;

  assign match   = valid_i && (key_q == cmd_i.key);
  assign rm_incl = link_i.rm | match;

  assign link_o.rm  = rm_incl;
  assign link_o.tok = tok_q;
  assign link_o.acc = acc_q;
  assign key_o      = key_q;

  always_comb begin
    unique case (cmd_i.op)
      OP_NONE:   key_d = key_q;
      OP_APPEND: key_d = (!valid_i && prev_valid_i) ? cmd_i.key : key_q;
      OP_SHIFT:  key_d = next_key_i;
      OP_REMOVE: key_d = rm_incl ? next_key_i : key_q;
      default:   key_d = key_q;
    endcase
  end

  // max step: fold own key into the running max as the token passes
  assign acc_d = (valid_i && (key_q > link_i.acc)) ? key_q : link_i.acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else begin
      tok_q <= link_i.tok;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    if (link_i.tok) begin
      acc_q <= acc_d;
    end
  end

endmodule

FILE: rtl/midi_mono_note_priority_parser_core.sv
// MIDI mono note-priority parser, top level. Takes one received MIDI byte per
// request and returns one result per byte: CV code, gate, trigger, pitch bend
// code, mod depth and held-note count. SysEx, realtime bytes and running status
// are tracked; channel messages act only on the channel in the listen register
// (cfg_we_i / cfg_wdata_i, written while idle). Notes live in a row of
// STACK_DEPTH mmnp_cell instances; the highest held note is found by a token
// that walks the row, one cell per clock. A byte passes from accept through
// S_EXEC to S_DONE when the note set is unchanged, and through S_SCAN between
// them when a new note, or a note off that leaves notes held, forces the max
// scan. One byte is in flight at a time; the next is accepted once the result
// is in the output register, even if that result has not yet been taken.
// Depends on mmnp_pkg and mmnp_cell.
module midi_mono_note_priority_parser_core #(
  parameter int unsigned STACK_DEPTH = mmnp_pkg::STACK_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration: listen channel
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  // byte request
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] midi_byte_i,
  // result request
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] cv_code_o,
  output logic       gate_o,
  output logic       trigger_o,
  output logic [7:0] bend_value_o,
  output logic [4:0] mod_depth_o,
  output logic [3:0] held_count_o
);
  import mmnp_pkg::*;

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  // parser phases (even: waiting for first data byte, odd: second)
  localparam logic [3:0] PH_NONE     = 4'd0;
  localparam logic [3:0] PH_OFF_KEY  = 4'd2;
  localparam logic [3:0] PH_OFF_VEL  = 4'd3;
  localparam logic [3:0] PH_ON_KEY   = 4'd4;
  localparam logic [3:0] PH_ON_VEL   = 4'd5;
  localparam logic [3:0] PH_PP_KEY   = 4'd6;
  localparam logic [3:0] PH_PP_VAL   = 4'd7;
  localparam logic [3:0] PH_PROG     = 4'd8;
  localparam logic [3:0] PH_CC_NUM   = 4'd10;
  localparam logic [3:0] PH_CC_VAL   = 4'd11;
  localparam logic [3:0] PH_CHP      = 4'd12;
  localparam logic [3:0] PH_BEND_LSB = 4'd14;
  localparam logic [3:0] PH_BEND_MSB = 4'd15;

  // status high nibbles
  localparam logic [3:0] ST_NOTE_OFF = 4'h8;
  localparam logic [3:0] ST_NOTE_ON  = 4'h9;
  localparam logic [3:0] ST_POLY_PR  = 4'hA;
  localparam logic [3:0] ST_CTRL     = 4'hB;
  localparam logic [3:0] ST_PROG     = 4'hC;
  localparam logic [3:0] ST_CHAN_PR  = 4'hD;
  localparam logic [3:0] ST_BEND     = 4'hE;

  // special bytes
  localparam logic [7:0] B_SYSEX_START = 8'hF0;
  localparam logic [7:0] B_SYSEX_END   = 8'hF7;
  localparam logic [7:0] B_RT_FIRST    = 8'hF8;
  localparam logic [7:0] B_SYS_RESET   = 8'hFF;

  // controller numbers
  localparam logic [6:0] CC_MOD_WHEEL  = 7'h01;
  localparam logic [6:0] CC_SOUND_OFF  = 7'h78;
  localparam logic [6:0] CC_RESET_CTRL = 7'h79;
  localparam logic [6:0] CC_NOTES_OFF  = 7'h7B;

  localparam logic [6:0] CV_NOTE_BASE = 7'd24;
  localparam logic [7:0] CV_TOP       = 8'd255;
  localparam logic [7:0] BEND_CENTER  = 8'd128;

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  logic [1:0]       state_q, state_d;
  logic [7:0]       byte_q, byte_d;
  logic [3:0]       listen_q;
  logic             sysex_q, sysex_d;
  logic [3:0]       phase_q, phase_d;
  logic [3:0]       chan_q, chan_d;
  logic [6:0]       dp0_q, dp0_d;
  logic [6:0]       dp1_q, dp1_d;
  logic [CW-1:0]    count_q, count_d;
  logic [7:0]       cv_q, cv_d;
  logic             gate_q, gate_d;
  logic             trig_q, trig_d;
  logic [7:0]       bend_q, bend_d;
  logic [4:0]       mod_q, mod_d;
  logic             start_q, start_d;
  logic             out_valid_q;

  logic             accept;
  logic             slot_free;
  logic             pass;
  logic             any_match;
  logic [CW-1:0]    count_dec;
  logic [6:0]       top_note;
  logic [6:0]       note_ofs;
  cmd_t             cmd;

  // ---------------------------------------------------------------------------
  // Note stack: row of cells
  // ---------------------------------------------------------------------------
  logic [STACK_DEPTH-1:0] valid;
  logic [KEY_W-1:0]       keys     [STACK_DEPTH];
  logic [KEY_W-1:0]       next_key [STACK_DEPTH];
  link_t                  links    [STACK_DEPTH+1];

  // head of the chain: no match yet, scan token enters here with max 0
  assign links[0].rm  = 1'b0;
  assign links[0].tok = start_q;
  assign links[0].acc = '0;

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    assign valid[i] = count_q > CW'(i);

    // tail cell pulls the new key in on a full-stack shift
    if (i == STACK_DEPTH - 1) begin : g_tail
      assign next_key[i] = cmd.key;
    end else begin : g_body
      assign next_key[i] = keys[i+1];
    end

    logic prev_valid;
    if (i == 0) begin : g_first
      assign prev_valid = 1'b1;
    end else begin : g_rest
      assign prev_valid = valid[i-1];
    end

    mmnp_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .valid_i      (valid[i]),
      .prev_valid_i (prev_valid),
      .next_key_i   (next_key[i]),
      .link_i       (links[i]),
      .key_o        (keys[i]),
      .link_o       (links[i+1])
    );
  end

  // rm ripples as a prefix OR, so the tail carries "key is held"
  assign any_match = links[STACK_DEPTH].rm;
  assign count_dec = count_q - (any_match ? CW'(1) : CW'(0));

  // CV from the scan result: 255 - 2*max(top - 24, 0)
  assign top_note = links[STACK_DEPTH].acc;
  assign note_ofs = (top_note < CV_NOTE_BASE) ? 7'd0 : (top_note - CV_NOTE_BASE);

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;

  // ---------------------------------------------------------------------------
  // Byte decode and message execution (S_EXEC), scan wait and output load
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    byte_d  = byte_q;
    sysex_d = sysex_q;
    phase_d = phase_q;
    chan_d  = chan_q;
    dp0_d   = dp0_q;
    dp1_d   = dp1_q;
    count_d = count_q;
    cv_d    = cv_q;
    gate_d  = gate_q;
    trig_d  = trig_q;
    bend_d  = bend_q;
    mod_d   = mod_q;
    start_d = 1'b0;
    pass    = 1'b0;
    cmd.op  = OP_NONE;
    cmd.key = dp0_q;   // note key is always the first data byte

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          byte_d  = midi_byte_i;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        trig_d = 1'b0;
        // byte classification
        if (sysex_q) begin
          // inside SysEx only the end marker matters
          if (byte_q == B_SYSEX_END) begin
            sysex_d = 1'b0;
          end
        end else if (byte_q < B_RT_FIRST) begin
          pass = 1'b1;
          if (byte_q[7]) begin
            if (byte_q == B_SYSEX_START) begin
              sysex_d = 1'b1;
            end else begin
              chan_d = byte_q[3:0];
            end
            phase_d = PH_NONE;
          end else if (phase_q[0]) begin
            dp1_d = byte_q[6:0];
          end else begin
            dp0_d = byte_q[6:0];
          end
        end else if (byte_q == B_SYS_RESET) begin
          bend_d  = BEND_CENTER;
          mod_d   = '0;
          count_d = '0;
          gate_d  = 1'b0;
        end
        // other realtime bytes: nothing

        // channel message state machine, only for our channel
        if (pass && (chan_d == listen_q)) begin
          unique case (phase_d)
            PH_NONE: begin
              // data byte here (no running status) has bit 7 low: ignored
              if (byte_q[7]) begin
                unique case (byte_q[7:4])
                  ST_NOTE_OFF: phase_d = PH_OFF_KEY;
                  ST_NOTE_ON:  phase_d = PH_ON_KEY;
                  ST_POLY_PR:  phase_d = PH_PP_KEY;
                  ST_CTRL:     phase_d = PH_CC_NUM;
                  ST_PROG:     phase_d = PH_PROG;
                  ST_CHAN_PR:  phase_d = PH_CHP;
                  ST_BEND:     phase_d = PH_BEND_LSB;
                  default:     phase_d = phase_d;
                endcase
              end
            end
            PH_OFF_KEY: phase_d = PH_OFF_VEL;
            PH_OFF_VEL: begin
              phase_d = PH_OFF_KEY;
              cmd.op  = OP_REMOVE;
              count_d = count_dec;
              if (count_dec == '0) begin
                gate_d = 1'b0;
              end else begin
                start_d = 1'b1;
              end
            end
            PH_ON_KEY: phase_d = PH_ON_VEL;
            PH_ON_VEL: begin
              phase_d = PH_ON_KEY;
              if (byte_q[6:0] == 7'd0) begin
                // velocity zero is a note off
                cmd.op  = OP_REMOVE;
                count_d = count_dec;
                if (count_dec == '0) begin
                  gate_d = 1'b0;
                end else begin
                  start_d = 1'b1;
                end
              end else if (!any_match) begin
                // new note; a full stack drops its oldest entry
                if (count_q == CW'(STACK_DEPTH)) begin
                  cmd.op = OP_SHIFT;
                end else begin
                  cmd.op  = OP_APPEND;
                  count_d = count_q + CW'(1);
                end
                start_d = 1'b1;
                gate_d  = 1'b1;
                trig_d  = 1'b1;
              end
            end
            PH_PP_KEY: phase_d = PH_PP_VAL;
            PH_PP_VAL: phase_d = PH_PP_KEY;
            PH_CC_NUM: phase_d = PH_CC_VAL;
            PH_CC_VAL: begin
              phase_d = PH_CC_NUM;
              unique case (dp0_q)
                CC_MOD_WHEEL: mod_d = byte_q[6:2];
                CC_SOUND_OFF, CC_NOTES_OFF: begin
                  count_d = '0;
                  gate_d  = 1'b0;
                end
                CC_RESET_CTRL: begin
                  bend_d = BEND_CENTER;
                  mod_d  = '0;
                end
                default: mod_d = mod_q;
              endcase
            end
            PH_BEND_LSB: phase_d = PH_BEND_MSB;
            PH_BEND_MSB: begin
              phase_d = PH_BEND_LSB;
              bend_d  = {byte_q[6:0], dp0_q[6]};
            end
            // program change / channel pressure park in their phase
            default: phase_d = phase_d;
          endcase
        end

        state_d = start_d ? S_SCAN : S_DONE;
      end

      S_SCAN: begin
        // token leaves the tail cell carrying the highest held key
        if (links[STACK_DEPTH].tok) begin
          cv_d    = CV_TOP - {note_ofs, 1'b0};
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      listen_q    <= '0;
      sysex_q     <= 1'b0;
      phase_q     <= PH_NONE;
      chan_q      <= '0;
      dp0_q       <= '0;
      dp1_q       <= '0;
      count_q     <= '0;
      cv_q        <= CV_TOP;
      gate_q      <= 1'b0;
      trig_q      <= 1'b0;
      bend_q      <= BEND_CENTER;
      mod_q       <= '0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        listen_q <= cfg_wdata_i;
      end
      sysex_q <= sysex_d;
      phase_q <= phase_d;
      chan_q  <= chan_d;
      dp0_q   <= dp0_d;
      dp1_q   <= dp1_d;
      count_q <= count_d;
      cv_q    <= cv_d;
      gate_q  <= gate_d;
      trig_q  <= trig_d;
      bend_q  <= bend_d;
      mod_q   <= mod_d;
      start_q <= start_d;
      if (state_q == S_DONE && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic [CW+3:0] count_ext;
  assign count_ext = {4'b0000, count_q};

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    if (state_q == S_DONE && slot_free) begin
      cv_code_o    <= cv_q;
      gate_o       <= gate_q;
      trigger_o    <= trig_q;
      bend_value_o <= bend_q;
      mod_depth_o  <= mod_q;
      held_count_o <= count_ext[3:0];
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/mmnp_checker.sv
// Port-level checks for midi_mono_note_priority_parser_core, bound to the top.
// Depends on the assertion macro header.
`include "midi_mono_note_priority_parser_core_macros.svh"

module mmnp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] cv_code_o,
  input logic       gate_o,
  input logic       trigger_o,
  input logic [3:0] held_count_o
);

  // a fresh note always leaves the gate open
  `MMNP_ASSERT(a_trig_gate, out_valid_o |-> (!trigger_o || gate_o), "trigger without gate")

  // notes held means gate open
  `MMNP_ASSERT(a_count_gate, (out_valid_o && (held_count_o != 4'd0)) |-> gate_o, "notes held but gate closed")

  // one byte in flight: no accept in the cycle after an accept
  `MMNP_ASSERT(a_one_inflight, (in_valid_i && in_ready_o) |=> !in_ready_o, "back-to-back accept")

  // a stalled result holds
  `MMNP_ASSERT(a_out_hold, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(cv_code_o) && $stable(held_count_o)), "stalled result changed")

endmodule

bind midi_mono_note_priority_parser_core mmnp_checker u_mmnp_checker (.*);

FILE: verif/tb.sv
// Self-checking bench for midi_mono_note_priority_parser_core: a directed byte table,
// then random MIDI traffic under several listen-channel settings.
// Depends on mmnp_pkg and the RTL top level; carries its own parser model.
module tb;
  import mmnp_pkg::*;

  localparam int unsigned DEPTH        = STACK_DEPTH_DEF;
  localparam int unsigned LIMIT_CYCLES = 400_000;
  // idle wait, sized to outlast the slowest byte, one that runs the max scan
  localparam int unsigned DRAIN_CYCLES = DEPTH + 12;
  localparam int unsigned PHASE_BYTES  = 325;
  localparam int unsigned N_DIR        = 41;
  localparam int unsigned HOLD_AFTER   = 500;
  localparam int unsigned HOLD_CYCLES  = 200;

  // byte values with a fixed meaning
  localparam logic [7:0] SYSEX_START = 8'hF0;
  localparam logic [7:0] SYSEX_END   = 8'hF7;
  localparam logic [7:0] RT_FIRST    = 8'hF8;
  localparam logic [7:0] RT_LAST     = 8'hFE;
  localparam logic [7:0] SYS_RESET   = 8'hFF;

  // channel status nibbles
  localparam logic [3:0] ST_NOTE_OFF = 4'h8;
  localparam logic [3:0] ST_NOTE_ON  = 4'h9;
  localparam logic [3:0] ST_POLY     = 4'hA;
  localparam logic [3:0] ST_CTRL     = 4'hB;
  localparam logic [3:0] ST_PROG     = 4'hC;
  localparam logic [3:0] ST_CHPRESS  = 4'hD;
  localparam logic [3:0] ST_BEND     = 4'hE;
  localparam logic [3:0] ST_SYSTEM   = 4'hF;

  // controller numbers that do something
  localparam logic [6:0] CC_MOD        = 7'h01;
  localparam logic [6:0] CC_SOUND_OFF  = 7'h78;
  localparam logic [6:0] CC_RESET_CTRL = 7'h79;
  localparam logic [6:0] CC_NOTES_OFF  = 7'h7B;

  // parser phase: even = waiting for first data byte, odd = second
  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_OFF_KEY = 4'd2,
    PH_OFF_VEL = 4'd3,
    PH_ON_KEY  = 4'd4,
    PH_ON_VEL  = 4'd5,
    PH_PP_KEY  = 4'd6,
    PH_PP_VAL  = 4'd7,
    PH_PROG    = 4'd8,
    PH_CC_NUM  = 4'd10,
    PH_CC_VAL  = 4'd11,
    PH_CHPRESS = 4'd12,
    PH_PB_LSB  = 4'd14,
    PH_PB_MSB  = 4'd15
  } midi_phase_e;

  typedef struct packed {
    logic [7:0] cv;
    logic       gate;
    logic       trig;
    logic [7:0] bend;
    logic [4:0] mod;
    logic [3:0] held;
  } midi_result_t;

  typedef struct packed {
    logic [7:0]   b;
    logic         has_want;
    midi_result_t want;
  } stim_row_t;

  localparam logic       CHK   = 1'b1;
  localparam logic [27:0] NOCHK = '0;

  // DUT ports, all driven from time zero
  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [3:0] cfg_wdata_i = '0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [7:0] midi_byte_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] cv_code_o;
  logic       gate_o;
  logic       trigger_o;
  logic [7:0] bend_value_o;
  logic [4:0] mod_depth_o;
  logic [3:0] held_count_o;

  midi_mono_note_priority_parser_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .midi_byte_i  (midi_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cv_code_o    (cv_code_o),
    .gate_o       (gate_o),
    .trigger_o    (trigger_o),
    .bend_value_o (bend_value_o),
    .mod_depth_o  (mod_depth_o),
    .held_count_o (held_count_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Parser model state (mirrors the block after reset)
  // ---------------------------------------------------------------------------
  logic [3:0]   listen_ch  = '0;
  logic         sysex_open = 1'b0;
  midi_phase_e  phase      = PH_IDLE;
  logic [3:0]   last_chan  = '0;
  logic [6:0]   data_byte [2] = '{7'd0, 7'd0};
  logic [6:0]   held_keys [DEPTH];
  int unsigned  held_n     = 0;
  logic [7:0]   cv_now     = 8'd255;
  logic         gate_now   = 1'b0;
  logic         fired      = 1'b0;
  logic [7:0]   bend_now   = 8'd128;
  logic [4:0]   mod_now    = '0;

  // results promised by accepted byte requests, oldest first
  midi_result_t pending_results [$];

  int unsigned bytes_in     = 0;
  int unsigned results_seen = 0;
  int unsigned errors       = 0;
  int unsigned settings     = 0;
  int unsigned triggers     = 0;
  int unsigned evictions    = 0;
  int unsigned sys_resets   = 0;
  int unsigned sysex_blocks = 0;
  int unsigned key_base     = 40;
  bit          tx_calm      = 1'b0;
  bit          rx_calm      = 1'b0;
  bit          hold_rx      = 1'b0;

  // CV follows the highest held key; keys below 24 pin it at full scale
  function automatic void refresh_pitch();
    logic [6:0]  top;
    int unsigned span;
    top = '0;
    for (int i = 0; i < held_n; i++) if (held_keys[i] > top) top = held_keys[i];
    span = (top < 24) ? 0 : top - 24;
    cv_now = 8'(255 - 2 * span);
  endfunction

  function automatic void key_press(input logic [6:0] k);
    for (int i = 0; i < held_n; i++) if (held_keys[i] == k) return;  // already held
    if (held_n >= DEPTH) begin
      // full: oldest key falls off the bottom
      for (int i = 0; i + 1 < DEPTH; i++) held_keys[i] = held_keys[i + 1];
      held_keys[DEPTH - 1] = k;
      evictions++;
    end else begin
      held_keys[held_n] = k;
      held_n++;
    end
    refresh_pitch();
    gate_now = 1'b1;
    fired    = 1'b1;
  endfunction

  function automatic void key_release(input logic [6:0] k);
    bit hit;
    hit = 1'b0;
    for (int i = 0; i < held_n; i++) begin
      if (hit) held_keys[i - 1] = held_keys[i];
      if (held_keys[i] == k) hit = 1'b1;
    end
    if (hit && held_n > 0) held_n--;
    if (held_n == 0) gate_now = 1'b0;
    else refresh_pitch();
  endfunction

  function automatic void controller();
    case (data_byte[0])
      CC_MOD:        mod_now = data_byte[1][6:2];
      CC_SOUND_OFF,
      CC_NOTES_OFF: begin
        held_n   = 0;
        gate_now = 1'b0;
      end
      CC_RESET_CTRL: begin
        bend_now = 8'd128;
        mod_now  = '0;
      end
      default: ;
    endcase
  endfunction

  // channel-message state machine; runs only for the listened channel
  function automatic void voice_step(input logic [7:0] b);
    case (phase)
      PH_IDLE: begin
        case (b[7:4])
          ST_NOTE_OFF: phase = PH_OFF_KEY;
          ST_NOTE_ON:  phase = PH_ON_KEY;
          ST_POLY:     phase = PH_PP_KEY;
          ST_CTRL:     phase = PH_CC_NUM;
          ST_PROG:     phase = PH_PROG;
          ST_CHPRESS:  phase = PH_CHPRESS;
          ST_BEND:     phase = PH_PB_LSB;
          default: ;
        endcase
      end
      PH_OFF_KEY: phase = PH_OFF_VEL;
      PH_OFF_VEL: begin
        phase = PH_OFF_KEY;
        key_release(data_byte[0]);
      end
      PH_ON_KEY: phase = PH_ON_VEL;
      PH_ON_VEL: begin
        phase = PH_ON_KEY;
        if (data_byte[1] == 0) key_release(data_byte[0]);  // velocity 0 means off
        else key_press(data_byte[0]);
      end
      PH_PP_KEY: phase = PH_PP_VAL;
      PH_PP_VAL: phase = PH_PP_KEY;
      PH_CC_NUM: phase = PH_CC_VAL;
      PH_CC_VAL: begin
        phase = PH_CC_NUM;
        controller();
      end
      PH_PB_LSB: phase = PH_PB_MSB;
      PH_PB_MSB: begin
        phase    = PH_PB_LSB;
        bend_now = {data_byte[1], data_byte[0][6]};
      end
      default: ;  // program change / channel pressure just sit in their phase
    endcase
  endfunction

  // advance the model by one byte and return what the block must answer
  function automatic midi_result_t next_outputs(input logic [7:0] b);
    midi_result_t r;
    bit           pass;
    pass  = 1'b0;
    fired = 1'b0;
    if (sysex_open) begin
      if (b == SYSEX_END) sysex_open = 1'b0;  // everything else swallowed
    end else if (b < RT_FIRST) begin
      if (b[7]) begin
        if (b == SYSEX_START) begin
          sysex_open = 1'b1;
          sysex_blocks++;
        end else begin
          last_chan = b[3:0];
        end
        phase = PH_IDLE;
      end else begin
        data_byte[phase[0]] = b[6:0];  // stored even for other channels
      end
      pass = 1'b1;
    end else if (b == SYS_RESET) begin
      bend_now = 8'd128;
      mod_now  = '0;
      held_n   = 0;
      gate_now = 1'b0;
      sys_resets++;
    end
    if (pass && last_chan == listen_ch) voice_step(b);
    if (fired) triggers++;
    r.cv   = cv_now;
    r.gate = gate_now;
    r.trig = fired;
    r.bend = bend_now;
    r.mod  = mod_now;
    r.held = held_n[3:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Byte request side
  // ---------------------------------------------------------------------------
  // Valid rises at a falling edge and holds until the block takes the byte.
  // A row with its own expectation pushes that; the model still advances.
  task automatic send_byte(input logic [7:0] b, input logic has_want,
                           input midi_result_t want);
    int unsigned  gap;
    midi_result_t model_res;
    if (bytes_in % 40 == 0) tx_calm = ($urandom_range(0, 3) == 0);
    gap = tx_calm ? 0 : $urandom_range(0, 8);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    midi_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    model_res = next_outputs(b);
    pending_results.push_back(has_want ? want : model_res);
    bytes_in++;
  endtask

  // random byte, now and then with a realtime byte slipped in ahead of it
  task automatic emit(input logic [7:0] b);
    logic [7:0] rt;
    if ($urandom_range(0, 29) == 0) begin
      rt = 8'($urandom_range(RT_FIRST, RT_LAST));
      send_byte(rt, 1'b0, '0);
    end
    send_byte(b, 1'b0, '0);
  endtask

  function automatic logic [7:0] any_data();
    logic [7:0] v;
    v = 8'($urandom_range(0, 127));
    return v;
  endfunction

  // keys mostly from a narrow window so duplicates and a full stack happen
  function automatic logic [7:0] pick_key();
    int unsigned sel;
    logic [7:0]  k;
    sel = $urandom_range(0, 7);
    if (sel < 5) k = 8'(key_base + $urandom_range(0, 11));
    else if (sel < 7) k = 8'($urandom_range(0, 127));
    else begin
      case ($urandom_range(0, 3))
        0:       k = 8'd0;
        1:       k = 8'd23;
        2:       k = 8'd24;
        default: k = 8'd127;
      endcase
    end
    return k;
  endfunction

  function automatic logic [7:0] velocity();
    logic [7:0] v;
    if ($urandom_range(0, 6) == 0) v = 8'd0;
    else v = 8'($urandom_range(1, 127));
    return v;
  endfunction

  // Mostly well-formed messages on the listened channel, with running status,
  // plus other channels, SysEx, system common/realtime/reset and raw noise.
  task automatic play_random(input int unsigned budget);
    int unsigned stop_at, pick, reps;
    logic [3:0]  chan;
    logic [7:0]  b;
    stop_at = bytes_in + budget;
    while (bytes_in < stop_at) begin
      pick = $urandom_range(0, 99);
      reps = $urandom_range(1, 4);
      chan = ($urandom_range(0, 4) != 0) ? listen_ch : 4'($urandom_range(0, 15));
      if (pick < 45) begin
        emit({ST_NOTE_ON, chan});
        repeat (reps) begin
          emit(pick_key());
          emit(velocity());
        end
      end else if (pick < 58) begin
        emit({ST_NOTE_OFF, chan});
        repeat (reps) begin
          emit(pick_key());
          emit(any_data());
        end
      end else if (pick < 68) begin
        emit({ST_CTRL, chan});
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: b = {1'b0, CC_MOD};
            4:          b = {1'b0, CC_SOUND_OFF};
            5:          b = {1'b0, CC_RESET_CTRL};
            6:          b = {1'b0, CC_NOTES_OFF};
            default:    b = any_data();
          endcase
          emit(b);
          emit(any_data());
        end
      end else if (pick < 73) begin
        emit({ST_BEND, chan});
        repeat (reps) begin
          emit(any_data());
          emit(($urandom_range(0, 3) == 0) ? 8'h7F : any_data());
        end
      end else if (pick < 75) begin
        emit({ST_POLY, chan});
        emit(pick_key());
        emit(any_data());
      end else if (pick < 77) begin
        emit({ST_PROG, chan});
        emit(any_data());
      end else if (pick < 79) begin
        emit({ST_CHPRESS, chan});
        emit(any_data());
      end else if (pick < 82) begin
        b = 8'($urandom_range(RT_FIRST, RT_LAST));
        send_byte(b, 1'b0, '0);
      end else if (pick < 85) begin
        emit(SYSEX_START);
        repeat ($urandom_range(0, 5)) begin
          b = 8'($urandom_range(0, 255));
          if (b == SYSEX_END) b = SYS_RESET;  // reset inside SysEx must be ignored
          emit(b);
        end
        emit(SYSEX_END);
      end else if (pick < 87) begin
        emit({ST_SYSTEM, 4'($urandom_range(1, 7))});
        repeat ($urandom_range(0, 2)) emit(any_data());
      end else if (pick < 88) begin
        emit(SYS_RESET);
      end else if (pick < 94) begin
        repeat (reps) emit(any_data());  // bare running-status data
      end else begin
        b = 8'($urandom_range(0, 255));
        emit(b);
      end
    end
  endtask

  // Listen register is only touched with nothing in flight.
  task automatic set_listen(input logic [3:0] ch);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= ch;
    @(negedge clk_i);
    cfg_we_i  <= 1'b0;
    listen_ch = ch;
    settings++;
  endtask

  // ---------------------------------------------------------------------------
  // Result request side
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(input string what, input int got, input int want);
    errors++;
    $display("mismatch at result %0d: %s got %0d expected %0d",
             results_seen, what, got, want);
  endtask

  initial begin : result_side
    int unsigned  gap;
    midi_result_t want;
    wait (rst_ni === 1'b1);
    forever begin
      if (results_seen % 40 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      gap = rx_calm ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      // long back-pressure stretch: the byte side keeps pushing meanwhile
      while (hold_rx) begin
        out_ready_i <= 1'b0;
        @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      results_seen++;
      if (pending_results.size() == 0) begin
        flag_mismatch("result with nothing pending", 0, 0);
      end else begin
        want = pending_results.pop_front();
        if (cv_code_o !== want.cv)      flag_mismatch("cv_code", cv_code_o, want.cv);
        if (gate_o !== want.gate)       flag_mismatch("gate", gate_o, want.gate);
        if (trigger_o !== want.trig)    flag_mismatch("trigger", trigger_o, want.trig);
        if (bend_value_o !== want.bend) flag_mismatch("bend_value", bend_value_o, want.bend);
        if (mod_depth_o !== want.mod)   flag_mismatch("mod_depth", mod_depth_o, want.mod);
        if (held_count_o !== want.held) flag_mismatch("held_count", held_count_o, want.held);
      end
    end
  end

  // receiver stall, counted here so it is independent of the byte stream
  initial begin : output_stall
    while (results_seen < HOLD_AFTER) @(posedge clk_i);
    hold_rx = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_rx = 1'b0;
  end

  initial begin : watchdog
    #(LIMIT_CYCLES * 20);
    $display("midi_mono_note_priority_parser_core regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    stim_row_t   dir_rows [N_DIR];
    logic [3:0]  plan [5];
    // expected fields: cv, gate, trig, bend, mod, held
    dir_rows = '{
      {8'h45, CHK, 8'd255, 1'b0, 1'b0, 8'd128, 5'd0, 4'd0},   // data, no running status
      {8'hF8, CHK, 8'd255, 1'b0, 1'b0, 8'd128, 5'd0, 4'd0},   // realtime
      {8'h90, NOCHK},
      {8'h7F, NOCHK},
      {8'h7F, CHK, 8'd49, 1'b1, 1'b1, 8'd128, 5'd0, 4'd1},    // top key, top velocity
      {8'h00, NOCHK},                                         // running status, key 0
      {8'h01, CHK, 8'd49, 1'b1, 1'b1, 8'd128, 5'd0, 4'd2},
      {8'h7F, NOCHK},
      {8'h40, CHK, 8'd49, 1'b1, 1'b0, 8'd128, 5'd0, 4'd2},    // duplicate note on
      {8'h00, NOCHK},
      {8'h00, CHK, 8'd49, 1'b1, 1'b0, 8'd128, 5'd0, 4'd1},    // velocity 0 = off
      {8'h80, NOCHK},
      {8'h05, NOCHK},
      {8'h00, NOCHK},                                         // off for key not held
      {8'h7F, NOCHK},
      {8'h00, CHK, 8'd49, 1'b0, 1'b0, 8'd128, 5'd0, 4'd0},    // stack emptied, CV kept
      {8'hE0, NOCHK},
      {8'h7F, NOCHK},
      {8'h7F, CHK, 8'd49, 1'b0, 1'b0, 8'd255, 5'd0, 4'd0},    // full bend
      {8'hB0, NOCHK},
      {8'h01, NOCHK},
      {8'h7F, CHK, 8'd49, 1'b0, 1'b0, 8'd255, 5'd31, 4'd0},   // full mod wheel
      {8'hFF, CHK, 8'd49, 1'b0, 1'b0, 8'd128, 5'd0, 4'd0},    // system reset
      {8'h79, NOCHK},                                         // CC phase survived reset
      {8'h00, NOCHK},
      {8'h78, NOCHK},
      {8'h00, NOCHK},
      {8'h7B, NOCHK},
      {8'h00, NOCHK},
      {8'hA0, NOCHK},
      {8'h3C, NOCHK},
      {8'h7F, NOCHK},
      {8'hC0, NOCHK},
      {8'h7F, NOCHK},
      {8'hD0, NOCHK},
      {8'h00, NOCHK},
      {8'hF0, NOCHK},
      {8'hFF, NOCHK},                                         // swallowed inside SysEx
      {8'hF7, NOCHK},
      {8'hF3, NOCHK},                                         // system common moves channel
      {8'h30, NOCHK}
    };
    plan = '{4'd15, 4'd0, 4'($urandom_range(1, 14)), 4'($urandom_range(0, 15)), 4'd15};

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // listen channel stays at its reset value for the table
    for (int i = 0; i < N_DIR; i++)
      send_byte(dir_rows[i].b, dir_rows[i].has_want, dir_rows[i].want);

    for (int p = 0; p < 5; p++) begin
      set_listen(plan[p]);
      key_base = $urandom_range(0, 116);
      play_random(PHASE_BYTES);
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d bytes over %0d listen-channel writes: %0d triggers, %0d evictions,",
             bytes_in, settings, triggers, evictions);
    $display("  %0d system resets, %0d SysEx blocks, %0d mismatches",
             sys_resets, sysex_blocks, errors);
    if (errors == 0) $display("midi_mono_note_priority_parser_core regression: pass");
    else $display("midi_mono_note_priority_parser_core regression: fail");
    $finish;
  end

endmodule
